@@ hw/rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared types, constants and helper functions for the complex number ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS       = 8;
    localparam int CORDIC_STEPS    = 14;
    localparam int ATAN_LEN        = 25;
    localparam int QUO_BITS        = 16;
    localparam int SQRT_STEPS      = 16;
    localparam int NUM_ITER        = (CORDIC_STEPS > QUO_BITS) ? CORDIC_STEPS : QUO_BITS;
    localparam int DIV_W           = (FRAC_BITS + 34 > 48) ? FRAC_BITS + 34 : 48;
    localparam int CX_W            = 44;
    localparam int CZ_W            = 35;
    localparam int CORDIC_PRESHIFT = 24;

    localparam logic signed [CZ_W-1:0] PI_Q30 = 35'sd3373259426;

    localparam logic signed [CZ_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
        35'sd843314857, 35'sd497837829, 35'sd263043837, 35'sd133525159,
        35'sd67021687,  35'sd33543516,  35'sd16775851,  35'sd8388437,
        35'sd4194283,   35'sd2097149,   35'sd1048576,   35'sd524288,
        35'sd262144,    35'sd131072,    35'sd65536,     35'sd32768,
        35'sd16384,     35'sd8192,      35'sd4096,      35'sd2048,
        35'sd1024,      35'sd512,       35'sd256,       35'sd128,
        35'sd64
    };

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_CONJ  = 3'd4,
        CMD_MAG   = 3'd5,
        CMD_PHASE = 3'd6,
        CMD_EQUAL = 3'd7
    } cau_cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } cau_status_t;

    typedef struct packed {
        cau_cmd_t           cmd;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } cau_req_t;

    typedef struct packed {
        logic signed [15:0] res_re;
        logic signed [15:0] res_im;
        logic               is_equal;
        cau_status_t        status;
    } cau_rsp_t;

    typedef struct packed {
        cau_cmd_t                cmd;
        logic signed [15:0]      fast_re;
        logic signed [15:0]      fast_im;
        logic                    fast_sat;
        logic                    fast_eq;
        logic [31:0]             den;
        logic                    dz;
        logic [DIV_W-1:0]        rem_re;
        logic [DIV_W-1:0]        rem_im;
        logic [QUO_BITS-1:0]     q_re;
        logic [QUO_BITS-1:0]     q_im;
        logic                    neg_re;
        logic                    neg_im;
        logic                    ovf_re;
        logic                    ovf_im;
        logic [31:0]             sq_v;
        logic [32:0]             sq_r;
        logic signed [CX_W-1:0]  cx;
        logic signed [CX_W-1:0]  cy;
        logic signed [CZ_W-1:0]  cz;
        logic                    czero;
    } cau_lane_t;

    typedef struct packed {
        logic               sat;
        logic signed [15:0] val;
    } cau_sat_t;

    function automatic cau_sat_t sat_q(input logic signed [47:0] v);
        cau_sat_t r;
        r.sat = 1'b0;
        r.val = v[15:0];
        if (v > 48'sd32767)
        begin
            r.sat = 1'b1;
            r.val = 16'sh7fff;
        end
        else if (v < -48'sd32768)
        begin
            r.sat = 1'b1;
            r.val = 16'sh8000;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/cau_iter_pipe.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit iteration pipeline
// One register stage per quotient bit, root bit and CORDIC rotation.
// ----------------------------------------------------------------------------
module cau_iter_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              head_valid,
    input  cau_pkg::cau_lane_t head,
    output logic              tail_valid,
    output cau_pkg::cau_lane_t tail
);
    import cau_pkg::*;

    cau_lane_t stage_reg  [NUM_ITER];
    logic      valid_reg  [NUM_ITER];
    cau_lane_t stage_next [NUM_ITER];
    cau_lane_t stage_cur  [NUM_ITER];
    logic      valid_cur  [NUM_ITER];

    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_stage
        localparam bit DO_DIV  = (i < QUO_BITS);
        localparam bit DO_SQRT = (i < SQRT_STEPS);
        localparam bit DO_ROT  = (i < CORDIC_STEPS);
        localparam int DK      = DO_DIV ? QUO_BITS - 1 - i : 0;
        localparam int SK      = DO_SQRT ? 2 * (SQRT_STEPS - 1 - i) : 0;
        localparam int RI      = DO_ROT ? i : 0;

        if (i == 0)
        begin : g_first
            assign stage_cur[i] = head;
            assign valid_cur[i] = head_valid;
        end
        else
        begin : g_rest
            assign stage_cur[i] = stage_reg[i-1];
            assign valid_cur[i] = valid_reg[i-1];
        end

        always_comb
        begin
            cau_lane_t              c;
            logic [DIV_W-1:0]       dk;
            logic [32:0]            bitv;
            logic [32:0]            t;
            logic signed [CX_W-1:0] xs;
            logic signed [CX_W-1:0] ys;
            c    = stage_cur[i];
            dk   = DIV_W'(c.den) << DK;
            bitv = 33'd1 << SK;
            t    = c.sq_r + bitv;
            xs   = c.cx >>> RI;
            ys   = c.cy >>> RI;
            if (DO_DIV)
            begin
                if (c.rem_re >= dk)
                begin
                    c.rem_re = c.rem_re - dk;
                    c.q_re[DK] = 1'b1;
                end
                if (c.rem_im >= dk)
                begin
                    c.rem_im = c.rem_im - dk;
                    c.q_im[DK] = 1'b1;
                end
            end
            if (DO_SQRT)
            begin
                if ({1'b0, c.sq_v} >= t)
                begin
                    c.sq_v = c.sq_v - t[31:0];
                    c.sq_r = (c.sq_r >> 1) + bitv;
                end
                else
                begin
                    c.sq_r = c.sq_r >> 1;
                end
            end
            if (DO_ROT)
            begin
                if (!c.cy[CX_W-1])
                begin
                    c.cx = c.cx + ys;
                    c.cy = c.cy - xs;
                    c.cz = c.cz + ATAN_Q30[RI];
                end
                else
                begin
                    c.cx = c.cx - ys;
                    c.cy = c.cy + xs;
                    c.cz = c.cz - ATAN_Q30[RI];
                end
            end
            stage_next[i] = c;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_cur[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    assign tail_valid = valid_reg[NUM_ITER-1];
    assign tail       = stage_reg[NUM_ITER-1];

endmodule

@@ hw/rtl/complex_arithmetic_unit_top.sv @@
// Complex arithmetic unit: add, sub, mul, div, conjugate, magnitude, phase, equal.
// Throughput: one request per cycle; the divider, square root and CORDIC are
// unrolled over the iteration stages, and a stalled response freezes the pipeline.
// Reset clears every stage valid bit and the response valid; payload is not reset.
// ----------------------------------------------------------------------------
// Complex arithmetic unit top level
// Product stage, setup stage, iteration pipeline and response register.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cau_pkg::cau_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cau_pkg::cau_rsp_t rsp
);
    import cau_pkg::*;

    logic en;

    logic               s1_valid_reg;
    cau_req_t           s1_req_reg;
    logic signed [31:0] p_rr_reg;
    logic signed [31:0] p_ii_reg;
    logic signed [31:0] p_ri_reg;
    logic signed [31:0] p_ir_reg;
    logic signed [31:0] p_bb_re_reg;
    logic signed [31:0] p_bb_im_reg;
    logic signed [31:0] p_aa_re_reg;
    logic signed [31:0] p_aa_im_reg;

    logic      s2_valid_reg;
    cau_lane_t s2_reg;
    cau_lane_t s2_next;

    logic      tail_valid;
    cau_lane_t tail;

    logic     rsp_valid_reg;
    cau_rsp_t rsp_reg;
    cau_rsp_t rsp_next;

    assign en        = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= req_valid;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= tail_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_req_reg  <= req;
            p_rr_reg    <= req.a_re * req.b_re;
            p_ii_reg    <= req.a_im * req.b_im;
            p_ri_reg    <= req.a_re * req.b_im;
            p_ir_reg    <= req.a_im * req.b_re;
            p_bb_re_reg <= req.b_re * req.b_re;
            p_bb_im_reg <= req.b_im * req.b_im;
            p_aa_re_reg <= req.a_re * req.a_re;
            p_aa_im_reg <= req.a_im * req.a_im;
            s2_reg      <= s2_next;
            rsp_reg     <= rsp_next;
        end
    end

    always_comb
    begin
        cau_lane_t          l;
        cau_sat_t           sr;
        cau_sat_t           si;
        logic signed [33:0] mr;
        logic signed [33:0] mi;
        logic signed [32:0] nre;
        logic signed [32:0] nim;
        logic [32:0]        mag_re;
        logic [32:0]        mag_im;
        logic [DIV_W-1:0]   dlim;
        logic signed [16:0] re17;
        logic signed [16:0] im17;
        l  = '0;
        sr = '0;
        si = '0;
        l.cmd = s1_req_reg.cmd;

        mr = (34'(p_rr_reg) - 34'(p_ii_reg) + (34'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        mi = (34'(p_ri_reg) + 34'(p_ir_reg) + (34'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        case (s1_req_reg.cmd)
            CMD_ADD:
            begin
                sr = sat_q(48'(s1_req_reg.a_re) + 48'(s1_req_reg.b_re));
                si = sat_q(48'(s1_req_reg.a_im) + 48'(s1_req_reg.b_im));
            end
            CMD_SUB:
            begin
                sr = sat_q(48'(s1_req_reg.a_re) - 48'(s1_req_reg.b_re));
                si = sat_q(48'(s1_req_reg.a_im) - 48'(s1_req_reg.b_im));
            end
            CMD_MUL:
            begin
                sr = sat_q(48'(mr));
                si = sat_q(48'(mi));
            end
            CMD_CONJ:
            begin
                sr = sat_q(48'(s1_req_reg.a_re));
                si = sat_q(-48'(s1_req_reg.a_im));
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        l.fast_re  = sr.val;
        l.fast_im  = si.val;
        l.fast_sat = sr.sat || si.sat;
        l.fast_eq  = (s1_req_reg.cmd == CMD_EQUAL) &&
                     (s1_req_reg.a_re == s1_req_reg.b_re) &&
                     (s1_req_reg.a_im == s1_req_reg.b_im);

        l.den    = 32'(p_bb_re_reg) + 32'(p_bb_im_reg);
        l.dz     = (l.den == 32'd0);
        nre      = 33'(p_rr_reg) + 33'(p_ii_reg);
        nim      = 33'(p_ir_reg) - 33'(p_ri_reg);
        l.neg_re = nre[32];
        l.neg_im = nim[32];
        mag_re   = nre[32] ? 33'(-nre) : 33'(nre);
        mag_im   = nim[32] ? 33'(-nim) : 33'(nim);
        l.rem_re = (DIV_W'(mag_re) << FRAC_BITS) + DIV_W'(l.den >> 1);
        l.rem_im = (DIV_W'(mag_im) << FRAC_BITS) + DIV_W'(l.den >> 1);
        dlim     = DIV_W'(l.den) << QUO_BITS;
        l.ovf_re = (l.rem_re >= dlim);
        l.ovf_im = (l.rem_im >= dlim);
        l.q_re   = '0;
        l.q_im   = '0;

        l.sq_v = 32'(p_aa_re_reg) + 32'(p_aa_im_reg);
        l.sq_r = '0;

        re17    = 17'(s1_req_reg.a_re);
        im17    = 17'(s1_req_reg.a_im);
        l.czero = (re17 == 17'sd0) && (im17 == 17'sd0);
        l.cz    = '0;
        if (re17 < 17'sd0)
        begin
            l.cz = (im17 >= 17'sd0) ? PI_Q30 : -PI_Q30;
            re17 = -re17;
            im17 = -im17;
        end
        l.cx = CX_W'(re17) <<< CORDIC_PRESHIFT;
        l.cy = CX_W'(im17) <<< CORDIC_PRESHIFT;

        s2_next = l;
    end

    cau_iter_pipe u_iter (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .head_valid (s2_valid_reg),
        .head       (s2_reg),
        .tail_valid (tail_valid),
        .tail       (tail)
    );

    always_comb
    begin
        cau_sat_t              sr;
        cau_sat_t              si;
        logic signed [16:0]    qr;
        logic signed [16:0]    qi;
        logic [16:0]           root;
        logic signed [CZ_W-1:0] zs;
        logic                  sat;
        sr   = '0;
        si   = '0;
        qr   = tail.neg_re ? -$signed({1'b0, tail.q_re}) : $signed({1'b0, tail.q_re});
        qi   = tail.neg_im ? -$signed({1'b0, tail.q_im}) : $signed({1'b0, tail.q_im});
        root = tail.sq_r[16:0] + 17'({1'b0, tail.sq_v} > tail.sq_r);
        zs   = (tail.cz + (35'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        rsp_next          = '0;
        rsp_next.is_equal = tail.fast_eq;
        case (tail.cmd)
            CMD_DIV:
            begin
                if (!tail.dz)
                begin
                    sr = sat_q(48'(qr));
                    si = sat_q(48'(qi));
                    if (tail.ovf_re)
                    begin
                        sr.sat = 1'b1;
                        sr.val = tail.neg_re ? 16'sh8000 : 16'sh7fff;
                    end
                    if (tail.ovf_im)
                    begin
                        si.sat = 1'b1;
                        si.val = tail.neg_im ? 16'sh8000 : 16'sh7fff;
                    end
                end
            end
            CMD_MAG:
            begin
                sr = sat_q(48'(root));
            end
            CMD_PHASE:
            begin
                if (!tail.czero)
                begin
                    sr = sat_q(48'(zs));
                end
            end
            default:
            begin
                sr.val = tail.fast_re;
                sr.sat = tail.fast_sat;
                si.val = tail.fast_im;
            end
        endcase
        sat = sr.sat || si.sat;
        rsp_next.res_re = sr.val;
        rsp_next.res_im = si.val;
        if ((tail.cmd == CMD_DIV) && tail.dz)
        begin
            rsp_next.status = ST_DIVZ;
        end
        else if (sat)
        begin
            rsp_next.status = ST_SAT;
        end
        else
        begin
            rsp_next.status = ST_OK;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status == ST_DIVZ) |->
        (rsp_reg.res_re == 16'sd0) && (rsp_reg.res_im == 16'sd0) && !rsp_reg.is_equal)
        else $error("divide by zero response carries data");
    a_equal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.is_equal |->
        (rsp_reg.status == ST_OK) && (rsp_reg.res_re == 16'sd0) &&
        (rsp_reg.res_im == 16'sd0))
        else $error("equal response carries data or status");
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |=> $stable(tail_valid))
        else $error("pipeline advanced while the response was stalled");
`endif

endmodule
